// File: sv/itdt_pkg.sv
package itdt_pkg;

  // ASCII bytes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_NL    = 8'h0A;

  // ending codes
  localparam logic [1:0] END_NONE = 2'd0;
  localparam logic [1:0] END_NL   = 2'd1;
  localparam logic [1:0] END_SEP  = 2'd2;

  // register map
  localparam int          CFG_AW       = 3;
  localparam logic        REG_SEP      = 1'b0;
  localparam logic [7:0]  SEP_RESET    = 8'd32;

  // commands to the converter
  typedef struct packed {
    logic start;  // load a new magnitude and begin conversion
    logic pop;    // shift the BCD word up one digit
  } itdt_cmd_t;

endpackage

// File: sv/itdt_dabble.sv
// Shift-and-add-3 binary to BCD converter, one bit per cycle.
module itdt_dabble import itdt_pkg::*; #(
  parameter int VALUE_BITS = 64,
  parameter int DIGITS     = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  itdt_cmd_t             cmd,
  input  logic [VALUE_BITS-1:0] start_value,
  output logic                  busy,
  output logic [3:0]            top_digit
);

  localparam int CW = $clog2(VALUE_BITS + 1);
  localparam int BW = 4 * DIGITS;

  logic [CW-1:0]         cnt_r;
  logic [VALUE_BITS-1:0] bin_r;
  logic [BW-1:0]         bcd_r;
  logic [BW-1:0]         bcd_adj;

  // add 3 to every digit of 5 or more before the shift
  for (genvar i = 0; i < DIGITS; i++) begin : g_adj
    assign bcd_adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? (bcd_r[4*i +: 4] + 4'd3)
                                                         : bcd_r[4*i +: 4];
  end

  assign busy      = (cnt_r != '0);
  assign top_digit = bcd_r[BW-1 -: 4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.start) begin
      cnt_r <= CW'(VALUE_BITS);
    end else if (busy) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      bin_r <= start_value;
      bcd_r <= '0;
    end else if (busy) begin
      bcd_r <= {bcd_adj[BW-2:0], bin_r[VALUE_BITS-1]};
      bin_r <= {bin_r[VALUE_BITS-2:0], 1'b0};
    end else if (cmd.pop) begin
      bcd_r <= {bcd_r[BW-5:0], 4'h0};
    end
  end

endmodule

// File: sv/integer_to_decimal_text_core.sv
// Integer to decimal ASCII text.
// Input channel (in_*): one word carries a 64-bit value (low VALUE_BITS bits
// used), a signed flag and an ending code (0 none, 1 newline, 2 separator,
// 3 acts as none). Output channel (out_*): one ASCII byte per word, with
// out_last on the final byte of each value: optional '-', the digits most
// significant first without leading zeros, then the optional ending byte.
// Configuration: APB-style port, register 0 at byte address 0 holds the
// separator byte (reset 0x20).
// Steps per value: binary to BCD conversion in the shared shift/add-3 unit,
// then leading zeros skipped (up to DIGITS-1), then one output word each for
// the optional sign, every digit and the optional ending byte, then back to
// idle. in_ready is high only while the sequencer is idle;
// one value is in work at a time. The output byte sits in a register, so the
// next value is accepted while the last byte still waits for out_ready.
// A stalled receiver simply holds the sequencer; nothing is dropped.
// Reset (rst_n low, synchronous) returns to idle, empties the output
// register and restores the separator byte.
module integer_to_decimal_text_core import itdt_pkg::*; #(
  parameter int VALUE_BITS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  // input words
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [63:0]       in_value_bits,
  input  logic              in_is_signed,
  input  logic [1:0]        in_ending,
  // output words
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_char,
  output logic              out_last,
  // configuration
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  // decimal digits needed for VALUE_BITS bits: ceil(VALUE_BITS * log10(2))
  localparam int DIGITS = (VALUE_BITS * 30103 + 99999) / 100000;
  localparam int DCW    = $clog2(DIGITS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_SKIP,
    S_SIGN,
    S_DIGIT,
    S_END
  } state_t;

  state_t          state_r, state_nxt;
  logic [DCW-1:0]  dig_cnt_r, dig_cnt_nxt;
  logic            neg_r, neg_nxt;
  logic [1:0]      ending_r, ending_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_char_r, out_char_nxt;
  logic            out_last_r, out_last_nxt;
  logic [7:0]      sep_r;

  logic                  accept;
  logic [VALUE_BITS-1:0] raw;
  logic                  raw_neg;
  logic [VALUE_BITS-1:0] magnitude;
  logic                  slot_free;
  logic                  has_tail;
  itdt_cmd_t             cmd;
  logic                  conv_busy;
  logic [3:0]            top_digit;

  // ---------------- configuration ----------------
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_SEP) ? {24'h0, sep_r} : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r <= SEP_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_SEP) begin
      sep_r <= cfg_pwdata[7:0];
    end
  end

  // ---------------- input and magnitude ----------------
  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign raw       = in_value_bits[VALUE_BITS-1:0];
  assign raw_neg   = in_is_signed && raw[VALUE_BITS-1];
  // most negative value negates to itself, which read unsigned is correct
  assign magnitude = raw_neg ? (~raw + 1'b1) : raw;

  itdt_dabble #(
    .VALUE_BITS (VALUE_BITS),
    .DIGITS     (DIGITS)
  ) u_dabble (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .start_value (magnitude),
    .busy        (conv_busy),
    .top_digit   (top_digit)
  );

  // ---------------- sequencer ----------------
  assign slot_free = !out_valid_r || out_ready;
  assign has_tail  = (ending_r == END_NL) || (ending_r == END_SEP);

  always_comb begin
    state_nxt     = state_r;
    dig_cnt_nxt   = dig_cnt_r;
    neg_nxt       = neg_r;
    ending_nxt    = ending_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    cmd           = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.start   = 1'b1;
          neg_nxt     = raw_neg;
          ending_nxt  = in_ending;
          dig_cnt_nxt = DCW'(DIGITS);
          state_nxt   = S_CONV;
        end
      end
      S_CONV: begin
        if (!conv_busy) begin
          state_nxt = S_SKIP;
        end
      end
      S_SKIP: begin
        // drop leading zeros, keeping at least the last digit
        if (top_digit == 4'd0 && dig_cnt_r > DCW'(1)) begin
          cmd.pop     = 1'b1;
          dig_cnt_nxt = dig_cnt_r - 1'b1;
        end else begin
          state_nxt = neg_r ? S_SIGN : S_DIGIT;
        end
      end
      S_SIGN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CH_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CH_ZERO + {4'h0, top_digit};
          out_last_nxt  = (dig_cnt_r == DCW'(1)) && !has_tail;
          cmd.pop       = 1'b1;
          dig_cnt_nxt   = dig_cnt_r - 1'b1;
          if (dig_cnt_r == DCW'(1)) begin
            state_nxt = has_tail ? S_END : S_IDLE;
          end
        end
      end
      S_END: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = (ending_r == END_NL) ? CH_NL : sep_r;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dig_cnt_r   <= '0;
      neg_r       <= 1'b0;
      ending_r    <= END_NONE;
      out_valid_r <= 1'b0;
      out_char_r  <= '0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dig_cnt_r   <= dig_cnt_nxt;
      neg_r       <= neg_nxt;
      ending_r    <= ending_nxt;
      out_valid_r <= out_valid_nxt;
      out_char_r  <= out_char_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  // ---------------- assertions ----------------
  // converter is never running while a new word can be taken
  a_idle_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !conv_busy)
    else $error("converter busy while sequencer idle");

  // a byte flagged last always returns the sequencer to idle
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_nxt && out_last_nxt && slot_free && state_r != S_IDLE)
      |=> (state_r == S_IDLE))
    else $error("last byte issued but sequencer not idle");

  // digit emission never runs past the digit count
  a_digit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIGIT || state_r == S_SKIP) |-> (dig_cnt_r != '0))
    else $error("digit count underflow");

  // digits emitted are decimal
  a_bcd_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIGIT) |-> (top_digit <= 4'd9))
    else $error("non-decimal digit from converter");

endmodule

// File: bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import itdt_pkg::*;

  localparam int VALUE_BITS = 64;
  // Max digit count of a 64-bit magnitude.
  localparam int DIGIT_CAP = 20;
  // Worst case per value: conversion, zero skip and every byte sent.
  localparam int CONV_CYCLES = VALUE_BITS + DIGIT_CAP + 22 + 2;
  localparam int SETTLE_CYCLES = 2 * CONV_CYCLES;
  // Cycles without any accepted word before the run is declared hung.
  localparam int HANG_LIMIT = 5000;
  localparam int WORDS_PER_PHASE = 46;

  // Ending code 3 has no name in the package; the block treats it as none.
  localparam logic [1:0] END_SPARE = 2'd3;
  // Register index with nothing behind it; writes to it must not stick.
  localparam int REG_SPARE = 1;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_byte_t;

  // Predicts the text for each accepted value and checks it byte by byte.
  class text_checker;
    text_byte_t expected_text[$];
    logic [7:0] separator;
    int         errors;

    function new();
      separator = SEP_RESET;
      errors = 0;
    endfunction

    function void write_register(int index, logic [31:0] value);
      if (index == int'(REG_SEP)) separator = value[7:0];
    endfunction

    function void note_value(logic [63:0] raw, logic signed_flag, logic [1:0] ending);
      logic [63:0] mask;
      logic [63:0] mag;
      logic [7:0]  digits[DIGIT_CAP];
      logic [7:0]  text[$];
      int          nd;
      int          i;
      mask = (VALUE_BITS == 64) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);
      mag = raw & mask;
      nd = 0;
      // Negative signed values: magnitude as unsigned, so the most negative one works.
      if (signed_flag && mag[VALUE_BITS-1]) begin
        text.push_back(CH_MINUS);
        mag = (~mag + 64'd1) & mask;
      end
      do begin
        digits[nd] = CH_ZERO + 8'(mag % 64'd10);
        nd++;
        mag = mag / 64'd10;
      end while (mag != 0 && nd < DIGIT_CAP);
      for (i = nd - 1; i >= 0; i--) text.push_back(digits[i]);
      if (ending == END_NL) begin
        text.push_back(CH_NL);
      end else if (ending == END_SEP) begin
        text.push_back(separator);
      end
      foreach (text[k]) expected_text.push_back('{text[k], k == text.size() - 1});
    endfunction

    function void check_byte(logic [7:0] ch, logic last);
      text_byte_t want;
      if (expected_text.size() == 0) begin
        $display("%0t: unexpected byte, expected none, actual char 0x%02h last %0b",
                 $time, ch, last);
        errors++;
        return;
      end
      want = expected_text.pop_front();
      if (ch !== want.ch) begin
        $display("%0t: out_char mismatch, expected 0x%02h actual 0x%02h",
                 $time, want.ch, ch);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: out_last mismatch, expected %0b actual %0b",
                 $time, want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [63:0]       in_value_bits = '0;
  logic              in_is_signed = 1'b0;
  logic [1:0]        in_ending = END_NONE;

  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [7:0]        out_char;
  logic              out_last;

  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0]       cfg_pwdata = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  text_checker checker_h = new();
  int          quiet_cycles = 0;

  integer_to_decimal_text_core #(.VALUE_BITS(VALUE_BITS)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_value_bits(in_value_bits),
    .in_is_signed(in_is_signed),
    .in_ending   (in_ending),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_char    (out_char),
    .out_last    (out_last),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly back to back, some short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Spread values over all digit counts, powers of ten and small negatives.
  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    logic [63:0] p;
    v = {$urandom, $urandom};
    p = 64'd1;
    case ($urandom_range(0, 3))
      1: v = v >> $urandom_range(1, 63);
      2: begin
        repeat ($urandom_range(0, 19)) p = p * 64'd10;
        v = p + 64'($urandom_range(0, 2)) - 64'd1;
      end
      3: v = ~(v >> $urandom_range(1, 63));
      default: ;
    endcase
    return v;
  endfunction

  // Sample both channels at the edge; inputs change only after it.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) checker_h.note_value(in_value_bits, in_is_signed, in_ending);
      if (out_valid && out_ready) checker_h.check_byte(out_char, out_last);
    end
  end

  // Hang detector: any accepted word on either side resets the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: ready bursts broken by random stalls.
  initial begin
    int stall;
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // One input word; valid stays up across back-to-back words.
  task automatic send_value(logic [63:0] v, logic signed_flag, logic [1:0] ending);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_value_bits <= v;
    in_is_signed  <= signed_flag;
    in_ending     <= ending;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold off the sender until every expected byte is out, then let the core settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (checker_h.expected_text.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, access cycle; the register takes the data at the access edge.
  task automatic write_register(int index, logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'(4 * index);
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    checker_h.write_register(index, value);
  endtask

  initial begin
    logic [7:0] sep_plan[5];
    sep_plan = '{8'h00, 8'hFF, 8'($urandom), 8'h2C, 8'($urandom)};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words with the separator at its reset value.
    send_value(64'd0, 1'b0, END_NONE);
    send_value(64'd0, 1'b1, END_NL);
    send_value('1, 1'b0, END_SEP);                          // 20 digits
    send_value('1, 1'b1, END_NL);                           // -1
    send_value(64'h8000_0000_0000_0000, 1'b1, END_SEP);     // most negative
    send_value(64'h8000_0000_0000_0000, 1'b0, END_NL);
    send_value(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, END_NONE);
    send_value(64'h7FFF_FFFF_FFFF_FFFF, 1'b0, END_SPARE);
    send_value(64'd9, 1'b0, END_NL);
    send_value(64'd10, 1'b1, END_NONE);
    send_value(64'd10000000000000000000, 1'b0, END_NL);
    send_value(64'd9999999999999999999, 1'b0, END_SEP);
    send_value(64'hFFFF_FFFF_FFFF_FFF6, 1'b1, END_NL);      // -10
    send_value(64'hFFFF_FFFF_FFFF_FFF6, 1'b0, END_NONE);
    send_value(64'h8000_0000_0000_0001, 1'b1, END_SPARE);

    // Write to an unmapped register: separator must stay at its reset value.
    wait_idle();
    write_register(REG_SPARE, 32'hFFFF_FF5A);
    send_value(64'd123, 1'b0, END_SEP);
    send_value(64'hFFFF_FFFF_FFFF_FE38, 1'b1, END_SEP);     // -456

    // Random phases, each under its own separator byte.
    foreach (sep_plan[p]) begin
      wait_idle();
      write_register(int'(REG_SEP), {24'($urandom), sep_plan[p]});
      repeat (WORDS_PER_PHASE) begin
        send_value(pick_value(), 1'($urandom), 2'($urandom_range(0, 3)));
      end
    end

    wait_idle();
    @(negedge clk);
    if (checker_h.errors == 0 && checker_h.expected_text.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
